FILE: rtl/union_find_maze_wall_removal_top_assert.svh
// Assertion macros for the maze wall removal block.
`ifndef UNION_FIND_MAZE_WALL_REMOVAL_TOP_ASSERT_SVH
`define UNION_FIND_MAZE_WALL_REMOVAL_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UFMW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ufmw check failed");

// Next-cycle implication, checked out of reset.
`define UFMW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ufmw check failed");

`endif

FILE: rtl/ufmw_pkg.sv
// Shared types and constants for the maze wall removal block.
`timescale 1ns / 1ps
package ufmw_pkg;
    localparam int MAX_SIDE = 32;
    localparam int CELL_MAX = MAX_SIDE * MAX_SIDE;
    localparam int WALL_MAX = 2 * CELL_MAX;
    localparam int CELL_W   = $clog2(CELL_MAX);
    localparam int WALL_W   = $clog2(WALL_MAX);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic SIDE_DOWN  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    localparam logic [1:0] REG_ROWS    = 2'd0;
    localparam logic [1:0] REG_COLUMNS = 2'd1;
    localparam logic [1:0] REG_PERFECT = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] random_word;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  cell_row;
        logic [4:0]  cell_column;
        logic        wall_side;
        logic        wall_opened;
        logic        sets_merged;
        logic        finished;
        logic [10:0] remaining_sets;
    } out_word_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [10:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [10:0] remainder;
    } div_rsp_t;
endpackage

FILE: rtl/ufmw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ufmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/ufmw_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ufmw_div
    import ufmw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [10:0] r_reg, r_next;
    logic [10:0] d_reg, d_next;
    logic [11:0] trial;
    logic [11:0] diff;

    assign trial = {r_reg, q_reg[31]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            q_next    = req.dividend;
            r_next    = 11'd0;
            d_next    = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = diff[10:0];
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = trial[10:0];
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;
endmodule

FILE: rtl/union_find_maze_wall_removal_top.sv
// Top level: randomized Kruskal maze wall removal with union-find.
// Start: walks every grid cell, down side then right side, to build walls and sets, then the result stage.
// Step: one divider run draws a wall, a second splits its cell into row and column, and the
//   root finds for both cells share the single read port of the parent table.
// Idle step (finished or no walls): straight to the result. One word at a time; a held result stalls input.
// Reset (aresetn low, synchronous): 16 by 16 grid, braid mode, no walls, one set.
`timescale 1ns / 1ps
module union_find_maze_wall_removal_top
    import ufmw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_wdata
);
`include "union_find_maze_wall_removal_top_assert.svh"

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_FILL  = 13'b0000000000010,
        S_DIVP  = 13'b0000000000100,
        S_RDW   = 13'b0000000001000,
        S_RDL   = 13'b0000000010000,
        S_WRP   = 13'b0000000100000,
        S_WRL   = 13'b0000001000000,
        S_DIVC  = 13'b0000010000000,
        S_FRD   = 13'b0000100000000,
        S_FCHK  = 13'b0001000000000,
        S_FGP   = 13'b0010000000000,
        S_MERGE = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]  rows_cfg_reg, cols_cfg_reg;
    logic        perfect_reg;
    logic [5:0]  used_rows_reg, used_cols_reg;
    logic [10:0] walls_left_reg, walls_left_next;
    logic [10:0] set_count_reg, set_count_next;
    logic [31:0] rnd_reg;
    logic [4:0]  r_reg, r_next, c_reg, c_next;
    logic        k_reg, k_next;
    logic [CELL_W-1:0] id_reg, id_next;
    logic [WALL_W-1:0] pick_reg, pick_next;
    logic [WALL_W-1:0] wall_reg, wall_next;
    logic [CELL_W-1:0] x_reg, x_next, ra_reg, ra_next;
    logic        phase_reg, phase_next;
    logic [4:0]  ar_reg, ar_next, ac_reg, ac_next;
    logic        opened_reg, opened_next, merged_reg, merged_next;
    logic        m_valid_reg;
    out_word_t   m_data_reg;

    logic              p_we, w_we;
    logic [CELL_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic [WALL_W-1:0] w_waddr, w_wdata, w_raddr, w_rdata;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [CELL_W-1:0] cell_a, cell_b;
    logic [11:0]       area;
    logic              wall_ok;
    logic [5:0]        r_inc, c_inc;
    logic              load_out;

    function automatic logic [5:0] clamp_side(input logic [5:0] v);
        logic [5:0] res;
        res = v;
        if (v == 6'd0) begin
            res = 6'd1;
        end else if (v > 6'(MAX_SIDE)) begin
            res = 6'(MAX_SIDE);
        end
        return res;
    endfunction

    ufmw_ram #(.WIDTH(CELL_W), .DEPTH(CELL_MAX)) u_parent (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    ufmw_ram #(.WIDTH(WALL_W), .DEPTH(WALL_MAX)) u_walls (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    ufmw_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    assign cell_a  = wall_reg[WALL_W-1:1];
    assign cell_b  = (wall_reg[0] == SIDE_RIGHT) ? cell_a + CELL_W'(1)
                                                 : cell_a + CELL_W'(used_cols_reg);
    assign area    = used_rows_reg * used_cols_reg;
    assign r_inc   = {1'b0, r_reg} + 6'd1;
    assign c_inc   = {1'b0, c_reg} + 6'd1;
    assign wall_ok = (k_reg == SIDE_DOWN) ? (r_inc < used_rows_reg) : (c_inc < used_cols_reg);
    assign s_ready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        walls_left_next = walls_left_reg;
        set_count_next  = set_count_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        k_next      = k_reg;
        id_next     = id_reg;
        pick_next   = pick_reg;
        wall_next   = wall_reg;
        x_next      = x_reg;
        ra_next     = ra_reg;
        phase_next  = phase_reg;
        ar_next     = ar_reg;
        ac_next     = ac_reg;
        opened_next = opened_reg;
        merged_next = merged_reg;
        p_we    = 1'b0;
        p_waddr = x_reg;
        p_wdata = p_rdata;
        p_raddr = x_reg;
        w_we    = 1'b0;
        w_waddr = pick_reg;
        w_wdata = w_rdata;
        w_raddr = pick_reg;
        div_req = '{start: 1'b0, dividend: rnd_reg, divisor: walls_left_reg};

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ar_next     = 5'd0;
                    ac_next     = 5'd0;
                    wall_next   = '0;
                    opened_next = 1'b0;
                    merged_next = 1'b0;
                    if (s_data.cmd == CMD_START) begin
                        walls_left_next = 11'd0;
                        r_next  = 5'd0;
                        c_next  = 5'd0;
                        k_next  = SIDE_DOWN;
                        id_next = '0;
                        state_next = S_FILL;
                    end else if (set_count_reg == 11'd1 || walls_left_reg == 11'd0) begin
                        state_next = S_DONE;
                    end else begin
                        div_req = '{start: 1'b1, dividend: s_data.random_word,
                                    divisor: walls_left_reg};
                        state_next = S_DIVP;
                    end
                end
            end
            S_FILL: begin
                p_we    = (k_reg == SIDE_DOWN);
                p_waddr = id_reg;
                p_wdata = id_reg;
                w_we    = wall_ok;
                w_waddr = walls_left_reg;
                w_wdata = {id_reg, k_reg};
                if (wall_ok) begin
                    walls_left_next = walls_left_reg + 11'd1;
                end
                if (k_reg == SIDE_DOWN) begin
                    k_next = SIDE_RIGHT;
                end else begin
                    k_next  = SIDE_DOWN;
                    id_next = id_reg + CELL_W'(1);
                    if (c_inc == used_cols_reg) begin
                        c_next = 5'd0;
                        r_next = r_reg + 5'd1;
                        if (r_inc == used_rows_reg) begin
                            set_count_next = area[10:0];
                            state_next     = S_DONE;
                        end
                    end else begin
                        c_next = c_reg + 5'd1;
                    end
                end
            end
            S_DIVP: begin
                if (div_rsp.done) begin
                    pick_next  = div_rsp.remainder;
                    state_next = S_RDW;
                end
            end
            S_RDW: begin
                w_raddr    = pick_reg;
                state_next = S_RDL;
            end
            S_RDL: begin
                wall_next  = w_rdata;
                w_raddr    = walls_left_reg - 11'd1;
                state_next = S_WRP;
            end
            S_WRP: begin
                // move the last wall into the drawn slot
                w_we       = 1'b1;
                w_waddr    = pick_reg;
                w_wdata    = w_rdata;
                state_next = S_WRL;
            end
            S_WRL: begin
                w_we            = 1'b1;
                w_waddr         = walls_left_reg - 11'd1;
                w_wdata         = wall_reg;
                walls_left_next = walls_left_reg - 11'd1;
                div_req = '{start: 1'b1, dividend: 32'(cell_a),
                            divisor: 11'(used_cols_reg)};
                state_next = S_DIVC;
            end
            S_DIVC: begin
                if (div_rsp.done) begin
                    ar_next    = div_rsp.quotient[4:0];
                    ac_next    = div_rsp.remainder[4:0];
                    x_next     = cell_a;
                    phase_next = 1'b0;
                    state_next = S_FRD;
                end
            end
            S_FRD: begin
                p_raddr    = x_reg;
                state_next = S_FCHK;
            end
            S_FCHK: begin
                if (p_rdata == x_reg) begin
                    if (!phase_reg) begin
                        ra_next    = x_reg;
                        x_next     = cell_b;
                        phase_next = 1'b1;
                        state_next = S_FRD;
                    end else begin
                        state_next = S_MERGE;
                    end
                end else begin
                    p_raddr    = p_rdata;
                    state_next = S_FGP;
                end
            end
            S_FGP: begin
                // path halving: point at the grandparent and hop there
                p_we       = 1'b1;
                p_waddr    = x_reg;
                p_wdata    = p_rdata;
                x_next     = p_rdata;
                state_next = S_FRD;
            end
            S_MERGE: begin
                if (ra_reg != x_reg) begin
                    p_we           = 1'b1;
                    p_waddr        = ra_reg;
                    p_wdata        = x_reg;
                    set_count_next = set_count_reg - 11'd1;
                    opened_next    = 1'b1;
                    merged_next    = 1'b1;
                end else begin
                    opened_next = !perfect_reg;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            rows_cfg_reg   <= 6'd16;
            cols_cfg_reg   <= 6'd16;
            perfect_reg    <= 1'b0;
            used_rows_reg  <= 6'd16;
            used_cols_reg  <= 6'd16;
            walls_left_reg <= 11'd0;
            set_count_reg  <= 11'd1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            walls_left_reg <= walls_left_next;
            set_count_reg  <= set_count_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROWS:    rows_cfg_reg <= cfg_wdata;
                    REG_COLUMNS: cols_cfg_reg <= cfg_wdata;
                    REG_PERFECT: perfect_reg  <= cfg_wdata[0];
                    default:     ;
                endcase
            end
            if (state_reg == S_IDLE && s_valid && s_data.cmd == CMD_START) begin
                used_rows_reg <= clamp_side(rows_cfg_reg);
                used_cols_reg <= clamp_side(cols_cfg_reg);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (state_reg == S_IDLE && s_valid) begin
            rnd_reg <= s_data.random_word;
        end
        r_reg      <= r_next;
        c_reg      <= c_next;
        k_reg      <= k_next;
        id_reg     <= id_next;
        pick_reg   <= pick_next;
        wall_reg   <= wall_next;
        x_reg      <= x_next;
        ra_reg     <= ra_next;
        phase_reg  <= phase_next;
        ar_reg     <= ar_next;
        ac_reg     <= ac_next;
        opened_reg <= opened_next;
        merged_reg <= merged_next;
        if (load_out) begin
            m_data_reg.cell_row       <= ar_reg;
            m_data_reg.cell_column    <= ac_reg;
            m_data_reg.wall_side      <= wall_reg[0];
            m_data_reg.wall_opened    <= opened_reg;
            m_data_reg.sets_merged    <= merged_reg;
            m_data_reg.finished       <= (set_count_reg == 11'd1);
            m_data_reg.remaining_sets <= set_count_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `UFMW_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `UFMW_ASSERT_NOW(a_finished_one_set, m_valid && m_data.finished,
                     m_data.remaining_sets == 11'd1)
    `UFMW_ASSERT_NOW(a_merge_opens, m_valid && m_data.sets_merged, m_data.wall_opened)
endmodule
